FILE: sv/mvpm_pkg.sv
// Shared types and codes for the multi-voice PCM mixer.
package mvpm_pkg;

  localparam int NUM_VOICES = 8;
  localparam int SAMPLE_AW = 16;
  localparam int SMP_W     = 16;
  localparam int LEN_W     = 17;
  localparam int KIND_W    = 3;
  localparam int VNUM_W    = 3;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;

  localparam logic signed [SMP_W-1:0] SAT_LOW  = 16'sh8000;
  localparam logic signed [SMP_W-1:0] SAT_HIGH = 16'sh7FFF;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_PLAY = 2'd1,
    OP_STOP = 2'd2,
    OP_MIX  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_MIX      = 3'd0,
    KIND_REPEATED = 3'd1,
    KIND_FINISHED = 3'd2,
    KIND_STARTED  = 3'd3,
    KIND_REFUSED  = 3'd4,
    KIND_STOPPED  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [SAMPLE_AW-1:0] start;
    logic [LEN_W-1:0]     length;
    logic [LEN_W-1:0]     position;
    logic                 rpt;
    logic                 ntf;
  } voice_t;

endpackage

FILE: sv/multi_voice_pcm_mixer.sv
// Multi-voice PCM mixer: sample store, voice table and mix sequencer.
//
// One request is taken at a time. A load writes the sample store; a play claims
// the lowest free voice or is refused, and a stop clears an active voice. A mix
// visits each active voice in S_VCALC, and S_ACC for a voice that contributes;
// each contributing voice needs one voice-table read and one sample-store read,
// both through single-port memories with registered read data. Events and the
// mixed sample leave through one output register, so a stalled output holds
// the sequencer. The sample store and the voice table come out of reset
// unwritten; only the active flags are cleared, and no clearing pass is run.
module multi_voice_pcm_mixer
  import mvpm_pkg::*;
#(
  parameter int VOICES = NUM_VOICES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // sample_address, sample_value, sound_start, sound_length, repeat_flag,
  // notify_flag, voice_index, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // voice_number, mixed_sample, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // result_kind
  output logic [KIND_W-1:0]     out_tuser,
  // last_result
  output logic                  out_tlast
);

  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SUM_W = SMP_W + 1 + $clog2(VOICES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_VCALC,
    S_ACC,
    S_SUM,
    S_START,
    S_REFUSE,
    S_STOP
  } state_t;

  state_t                    state_r;
  logic [VOICES-1:0]         active_r;
  logic [VOICES-1:0]         mask_r;
  logic [VW-1:0]             cur_r;
  logic signed [SUM_W-1:0]   sum_r;

  logic                      out_tvalid_r;
  kind_t                     out_kind_r;
  logic [VNUM_W-1:0]         out_voice_r;
  logic [SMP_W-1:0]          out_smp_r;
  logic                      out_last_r;

  voice_t                    tbl_mem [VOICES];
  voice_t                    tbl_rdata_r;
  logic                      tbl_re, tbl_we;
  logic [VW-1:0]             tbl_addr;
  voice_t                    tbl_wdata;

  logic signed [SMP_W-1:0]   store_mem [2**SAMPLE_AW];
  logic signed [SMP_W-1:0]   store_rdata_r;
  logic                      store_re, store_we;
  logic [SAMPLE_AW-1:0]      store_addr;

  op_t                       op;
  logic [SAMPLE_AW-1:0]      f_addr, f_start;
  logic [SMP_W-1:0]          f_value;
  logic [LEN_W-1:0]          f_length;
  logic                      f_rpt, f_ntf;
  logic [2:0]                f_vidx;
  logic [VW-1:0]             stop_idx;
  logic                      stop_hit;

  logic                      in_acc, out_free;
  logic [VOICES-1:0]         scan_vec, free_vec;
  logic [VW-1:0]             scan_idx, free_idx;
  logic                      scan_found, free_found;

  logic                      at_end, wrap, contrib, need_evt, calc_go;
  logic [LEN_W-1:0]          rd_pos;

  logic                      out_load;
  kind_t                     out_kind;
  logic [VNUM_W-1:0]         out_voice;
  logic [SMP_W-1:0]          out_smp;
  logic                      out_last;

  function automatic logic [VW-1:0] first_set(input logic [VOICES-1:0] vec);
    logic [VW-1:0] idx;
    idx = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (vec[i]) idx = VW'(i);
    end
    return idx;
  endfunction

  assign op       = op_t'(in_tuser);
  assign f_addr   = in_tdata[15:0];
  assign f_value  = in_tdata[31:16];
  assign f_start  = in_tdata[47:32];
  assign f_length = in_tdata[64:48];
  assign f_rpt    = in_tdata[65];
  assign f_ntf    = in_tdata[66];
  assign f_vidx   = in_tdata[69:67];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign stop_idx = VW'(f_vidx);
  assign stop_hit = ({29'd0, f_vidx} < 32'(VOICES)) && active_r[stop_idx];

  assign scan_vec   = (state_r == S_IDLE) ? active_r : (active_r & mask_r);
  assign scan_found = |scan_vec;
  assign scan_idx   = first_set(scan_vec);
  assign free_vec   = ~active_r;
  assign free_found = |free_vec;
  assign free_idx   = first_set(free_vec);

  assign at_end   = tbl_rdata_r.position >= tbl_rdata_r.length;
  assign wrap     = tbl_rdata_r.rpt && (tbl_rdata_r.length != '0);
  assign contrib  = !at_end || wrap;
  assign need_evt = at_end && tbl_rdata_r.ntf;
  assign calc_go  = !need_evt || out_free;
  assign rd_pos   = at_end ? '0 : tbl_rdata_r.position;

  always_comb begin
    tbl_re     = 1'b0;
    tbl_we     = 1'b0;
    tbl_addr   = scan_idx;
    tbl_wdata  = tbl_rdata_r;
    store_re   = 1'b0;
    store_we   = 1'b0;
    store_addr = f_addr;
    out_load   = 1'b0;
    out_kind   = KIND_MIX;
    out_voice  = '0;
    out_smp    = '0;
    out_last   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op)
            OP_LOAD: store_we = 1'b1;
            OP_PLAY: begin
              tbl_we    = free_found;
              tbl_addr  = free_idx;
              tbl_wdata = '{start: f_start, length: f_length, position: '0,
                            rpt: f_rpt, ntf: f_ntf};
            end
            OP_STOP: begin
              tbl_re   = stop_hit;
              tbl_addr = stop_idx;
            end
            OP_MIX: tbl_re = scan_found;
            default: ;
          endcase
        end
      end
      S_VCALC: begin
        tbl_addr = cur_r;
        if (calc_go) begin
          out_load  = need_evt;
          out_kind  = wrap ? KIND_REPEATED : KIND_FINISHED;
          out_voice = VNUM_W'(cur_r);
          out_last  = 1'b0;
          if (contrib) begin
            store_re   = 1'b1;
            store_addr = tbl_rdata_r.start + rd_pos[SAMPLE_AW-1:0];
            tbl_we     = 1'b1;
            tbl_wdata.position = rd_pos + LEN_W'(1);
          end else begin
            tbl_re = scan_found;
            tbl_addr = scan_idx;
          end
        end
      end
      S_ACC: tbl_re = scan_found;
      S_SUM: begin
        out_load = out_free;
        if (sum_r > SUM_W'(SAT_HIGH)) begin
          out_smp = SAT_HIGH;
        end else if (sum_r < SUM_W'(SAT_LOW)) begin
          out_smp = SAT_LOW;
        end else begin
          out_smp = sum_r[SMP_W-1:0];
        end
      end
      S_START: begin
        out_load  = out_free;
        out_kind  = KIND_STARTED;
        out_voice = VNUM_W'(cur_r);
      end
      S_REFUSE: begin
        out_load = out_free;
        out_kind = KIND_REFUSED;
      end
      S_STOP: begin
        out_load  = tbl_rdata_r.ntf && out_free;
        out_kind  = KIND_STOPPED;
        out_voice = VNUM_W'(cur_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_addr] <= tbl_wdata;
    if (tbl_re) tbl_rdata_r <= tbl_mem[tbl_addr];
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_addr] <= f_value;
    if (store_re) store_rdata_r <= store_mem[store_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (op)
              OP_LOAD: ;
              OP_PLAY: begin
                if (free_found) begin
                  active_r[free_idx] <= 1'b1;
                  cur_r              <= free_idx;
                  state_r            <= S_START;
                end else begin
                  state_r <= S_REFUSE;
                end
              end
              OP_STOP: begin
                if (stop_hit) begin
                  active_r[stop_idx] <= 1'b0;
                  cur_r              <= stop_idx;
                  state_r            <= S_STOP;
                end
              end
              OP_MIX: begin
                sum_r <= '0;
                if (scan_found) begin
                  mask_r  <= ~(VOICES'(1) << scan_idx);
                  cur_r   <= scan_idx;
                  state_r <= S_VCALC;
                end else begin
                  state_r <= S_SUM;
                end
              end
              default: ;
            endcase
          end
        end
        S_VCALC: begin
          if (calc_go) begin
            if (contrib) begin
              state_r <= S_ACC;
            end else begin
              active_r[cur_r] <= 1'b0;
              if (scan_found) begin
                mask_r[scan_idx] <= 1'b0;
                cur_r            <= scan_idx;
              end else begin
                state_r <= S_SUM;
              end
            end
          end
        end
        S_ACC: begin
          sum_r <= sum_r + SUM_W'(store_rdata_r);
          if (scan_found) begin
            mask_r[scan_idx] <= 1'b0;
            cur_r            <= scan_idx;
            state_r          <= S_VCALC;
          end else begin
            state_r <= S_SUM;
          end
        end
        S_SUM, S_START, S_REFUSE: begin
          if (out_free) state_r <= S_IDLE;
        end
        S_STOP: begin
          if (!tbl_rdata_r.ntf || out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (out_load) begin
      out_kind_r  <= out_kind;
      out_voice_r <= out_voice;
      out_smp_r   <= out_smp;
      out_last_r  <= out_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_smp_r, out_voice_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_acc_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |-> $past(state_r) == S_VCALC)
    else $error("accumulate without a voice update");

  a_one_claim: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(active_r & ~$past(active_r)) <= 1)
    else $error("more than one voice claimed at once");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten while held");

  a_cur_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_VCALC |-> active_r[cur_r])
    else $error("updating an idle voice");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the multi-voice PCM mixer: random and directed requests.
`timescale 1ns / 1ps

module tb_top;
  import mvpm_pkg::*;

  localparam int VOICES = NUM_VOICES;
  localparam int REQUEST_COUNT = 310;

  typedef struct packed {
    logic [1:0]              pad;
    logic [VNUM_W-1:0]       voice_index;
    logic                    ntf;
    logic                    rpt;
    logic [LEN_W-1:0]        length;
    logic [SAMPLE_AW-1:0]    start;
    logic signed [SMP_W-1:0] value;
    logic [SAMPLE_AW-1:0]    addr;
  } mix_request_t;

  typedef struct packed {
    logic [4:0]              pad;
    logic signed [SMP_W-1:0] sample;
    logic [VNUM_W-1:0]       vnum;
  } mix_out_t;

  typedef struct packed {
    kind_t                   kind;
    logic [VNUM_W-1:0]       vnum;
    logic signed [SMP_W-1:0] sample;
    logic                    last;
  } mix_event_t;

  class mixer_scoreboard;
    logic [SMP_W-1:0] store_word [0:65535];
    bit               word_written [0:65535];
    bit               busy [0:VOICES-1];
    voice_t           voice [0:VOICES-1];
    mix_event_t       expected_events[$];
    mix_event_t       batch[$];
    int               mismatches;

    function void add(kind_t kind, int v, int sample);
      mix_event_t e;
      e.kind = kind;
      e.vnum = v[VNUM_W-1:0];
      e.sample = sample[SMP_W-1:0];
      e.last = 1'b0;
      batch.push_back(e);
    endfunction

    // first store word the next mix would read that was never loaded, or -1
    function int next_unwritten_read();
      logic [LEN_W-1:0]     pos;
      logic [SAMPLE_AW-1:0] a;
      for (int v = 0; v < VOICES; v++) begin
        if (!busy[v]) continue;
        pos = voice[v].position;
        if (pos >= voice[v].length) begin
          if (voice[v].rpt && voice[v].length != 0) pos = '0;
          else continue;
        end
        a = voice[v].start + pos[SAMPLE_AW-1:0];
        if (!word_written[a]) return int'(a);
      end
      return -1;
    endfunction

    function void note_request(op_t op, mix_request_t req);
      int                   free_v;
      int                   sum;
      logic [SAMPLE_AW-1:0] a;
      batch.delete();
      case (op)
        OP_LOAD: begin
          store_word[req.addr] = req.value;
          word_written[req.addr] = 1'b1;
        end
        OP_PLAY: begin
          free_v = -1;
          for (int v = 0; v < VOICES; v++)
            if (!busy[v] && free_v < 0) free_v = v;
          if (free_v >= 0) begin
            busy[free_v] = 1'b1;
            voice[free_v].start = req.start;
            voice[free_v].length = req.length;
            voice[free_v].position = '0;
            voice[free_v].rpt = req.rpt;
            voice[free_v].ntf = req.ntf;
            add(KIND_STARTED, free_v, 0);
          end else begin
            add(KIND_REFUSED, 0, 0);
          end
        end
        OP_STOP: begin
          if (busy[req.voice_index]) begin
            busy[req.voice_index] = 1'b0;
            if (voice[req.voice_index].ntf) add(KIND_STOPPED, req.voice_index, 0);
          end
        end
        default: begin
          sum = 0;
          for (int v = 0; v < VOICES; v++) begin
            if (!busy[v]) continue;
            if (voice[v].position >= voice[v].length) begin
              if (voice[v].rpt && voice[v].length != 0) begin
                if (voice[v].ntf) add(KIND_REPEATED, v, 0);
                voice[v].position = '0;
              end else begin
                if (voice[v].ntf) add(KIND_FINISHED, v, 0);
                busy[v] = 1'b0;
                continue;
              end
            end
            a = voice[v].start + voice[v].position[SAMPLE_AW-1:0];
            sum += $signed(store_word[a]);
            voice[v].position += 1'b1;
          end
          if (sum < int'(SAT_LOW)) sum = int'(SAT_LOW);
          if (sum > int'(SAT_HIGH)) sum = int'(SAT_HIGH);
          add(KIND_MIX, 0, sum);
        end
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) expected_events.push_back(batch[i]);
    endfunction

    function void check_result(mix_event_t got);
      mix_event_t exp;
      if (expected_events.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind %0d voice %0d sample %0d last %0b",
                   got.kind, got.vnum, got.sample, got.last);
        mismatches++;
        return;
      end
      exp = expected_events.pop_front();
      if (got !== exp) begin
        if (mismatches < 10) begin
          $display("mismatch: expected kind %0d voice %0d sample %0d last %0b",
                   exp.kind, exp.vnum, exp.sample, exp.last);
          $display("          got kind %0d voice %0d sample %0d last %0b",
                   got.kind, got.vnum, got.sample, got.last);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;

  mixer_scoreboard sb = new();
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_off;
  int items_sent;

  multi_voice_pcm_mixer #(.VOICES(VOICES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin : rx_ready
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  initial begin : rx_monitor
    mix_out_t   o;
    mix_event_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        o = out_tdata;
        got.kind = kind_t'(out_tuser);
        got.vnum = o.vnum;
        got.sample = o.sample;
        got.last = out_tlast;
        sb.check_result(got);
      end
    end
  end

  function automatic mix_request_t noise_fields();
    mix_request_t r;
    r.pad = '0;
    r.voice_index = VNUM_W'($urandom_range(0, VOICES - 1));
    r.ntf = 1'($urandom_range(0, 1));
    r.rpt = 1'($urandom_range(0, 1));
    r.length = LEN_W'($urandom_range(0, 65536));
    r.start = SAMPLE_AW'($urandom());
    r.value = SMP_W'($urandom());
    r.addr = SAMPLE_AW'($urandom());
    return r;
  endfunction

  function automatic logic signed [SMP_W-1:0] load_value();
    case ($urandom_range(0, 7))
      0:       return SAT_HIGH;
      1:       return SAT_LOW;
      default: return SMP_W'($urandom());
    endcase
  endfunction

  function automatic logic [SAMPLE_AW-1:0] pool_address();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_AW'($urandom());
      1, 2:    return SAMPLE_AW'($urandom_range(65526, 65535));
      default: return SAMPLE_AW'($urandom_range(0, 47));
    endcase
  endfunction

  task automatic send_request(op_t op, mix_request_t req);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= req;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, req);
    items_sent++;
  endtask

  task automatic load(logic [SAMPLE_AW-1:0] a, logic signed [SMP_W-1:0] val);
    mix_request_t r;
    r = noise_fields();
    r.addr = a;
    r.value = val;
    send_request(OP_LOAD, r);
  endtask

  task automatic play(logic [SAMPLE_AW-1:0] start, logic [LEN_W-1:0] len, bit rpt, bit ntf);
    mix_request_t r;
    r = noise_fields();
    r.start = start;
    r.length = len;
    r.rpt = rpt;
    r.ntf = ntf;
    send_request(OP_PLAY, r);
  endtask

  task automatic stop(int v);
    mix_request_t r;
    r = noise_fields();
    r.voice_index = v[VNUM_W-1:0];
    send_request(OP_STOP, r);
  endtask

  // back-fills any store word the mix would read before it was loaded
  task automatic mix();
    int a;
    a = sb.next_unwritten_read();
    while (a >= 0) begin
      load(a[SAMPLE_AW-1:0], load_value());
      a = sb.next_unwritten_read();
    end
    send_request(OP_MIX, noise_fields());
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      load(pool_address(), load_value());
    end else if (r < 45) begin
      case ($urandom_range(0, 19))
        0:       play(pool_address(), 17'd65536, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        1:       play(pool_address(), LEN_W'($urandom_range(0, 65536)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        2:       play(pool_address(), '0, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        default: play(pool_address(), LEN_W'($urandom_range(1, 10)),
                      1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
      endcase
    end else if (r < 60) begin
      stop($urandom_range(0, VOICES - 1));
    end else begin
      mix();
    end
  endtask

  initial begin : stimulus
    int phase;
    bit held;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_off = 0;
    items_sent = 0;
    held = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    load(16'd0, SAT_HIGH);
    load(16'd1, SAT_HIGH);
    load(16'hFFFF, SAT_LOW);
    load(16'd2, SAT_LOW);
    play(16'd0, 17'd2, 1'b1, 1'b1);
    play(16'd0, 17'd2, 1'b0, 1'b1);
    play(16'hFFFF, 17'd2, 1'b1, 1'b0);
    play(16'd5, 17'd0, 1'b1, 1'b1);
    play(16'd1, 17'd65536, 1'b0, 1'b1);
    play(16'd0, 17'd3, 1'b0, 1'b0);
    play(16'd1, 17'd1, 1'b1, 1'b1);
    play(16'd2, 17'd1, 1'b0, 1'b1);
    play(16'd3, 17'd4, 1'b1, 1'b1);
    mix();
    mix();
    load(16'd0, SAT_LOW);
    load(16'd1, SAT_LOW);
    mix();
    stop(3);
    stop(4);
    stop(2);
    stop(7);
    play(16'd0, 17'd1, 1'b0, 1'b1);
    mix();

    while (items_sent < REQUEST_COUNT) begin
      phase = items_sent * 4 / REQUEST_COUNT;
      case (phase)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
      endcase
      if (!held && items_sent >= 50) begin
        hold_off = 400;
        held = 1'b1;
      end
      random_request();
    end
    in_tvalid <= 1'b0;

    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_events.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: filelist.f
sv/mvpm_pkg.sv
sv/multi_voice_pcm_mixer.sv
bench/tb_top.sv
